// ===== src/bpf_pkg.sv =====
`timescale 1ns / 1ps

package bpf_pkg;

   localparam int COORD_W = 24;
   localparam int ACC_W   = 60;
   localparam int T_W     = 17;
   localparam int W_W     = 33;
   localparam int SEG_W   = 7;

   localparam logic [1:0] KIND_MOVE  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_QUAD  = 2'd2;
   localparam logic [1:0] KIND_CUBIC = 2'd3;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [COORD_W-1:0] ctrl1_x;
      logic signed [COORD_W-1:0] ctrl1_y;
      logic signed [COORD_W-1:0] ctrl2_x;
      logic signed [COORD_W-1:0] ctrl2_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [SEG_W-1:0]          segments;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic                      last_point;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       t_step;
      logic       prod1;
      logic       prod2;
      logic       weight;
      logic       mul;
      logic [1:0] sel;
      logic       acc_clr;
      logic       acc_en;
      logic       emit_point;
      logic       emit_end;
      logic       pen_update;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } status_type;

endpackage

// ===== src/bezier_path_flattener_top.sv =====
`timescale 1ns / 1ps

// Flattens move, line, quadratic and cubic path commands into Q15.8 points.
// One command is taken at a time. A move or line goes from idle to the emit state,
// which writes its end point to the output register once that register is free.
// A curve first forms 1/segments in a bit-serial divider, then computes each point
// with the single shared multiply-accumulate sequence (t step, weight products,
// four coordinate products, accumulate, round). A finished point waits in an output
// register while the next is computed.

module bezier_path_flattener_top #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bpf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpf_pkg::rsp_type rsp_data
);

   bpf_pkg::cmd_type    cmd;
   bpf_pkg::status_type status;

   bpf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_curve (req_data.kind[1]),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bpf_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/bpf_datapath.sv =====
`timescale 1ns / 1ps

module bpf_datapath #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  bpf_pkg::req_type    req_data,
   input  bpf_pkg::cmd_type    cmd,
   output bpf_pkg::status_type status,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output bpf_pkg::rsp_type    rsp_data
);

   localparam int IW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [bpf_pkg::SEG_W-1:0] SEG_MAX = bpf_pkg::SEG_W'(MAX_SEGMENTS);
   localparam logic [bpf_pkg::T_W-1:0]   ONE_T   = bpf_pkg::T_W'(65536);

   logic [1:0]                         kind_ff;
   logic signed [bpf_pkg::COORD_W-1:0] c1x_ff, c1y_ff, c2x_ff, c2y_ff, ex_ff, ey_ff;
   logic signed [bpf_pkg::COORD_W-1:0] pen_x_ff, pen_y_ff;
   logic [bpf_pkg::SEG_W-1:0]          seg_ff, seg_eff;
   logic [5:0]                         rem_ff, rem_in;
   logic [bpf_pkg::T_W-1:0]            dq_ff, dq_in;
   logic [6:0]                         div_shift;
   logic [bpf_pkg::T_W-1:0]            q_ff, q_in;
   logic [5:0]                         r_ff, r_in;
   logic [6:0]                         r_sum;
   logic [IW-1:0]                      i_ff;
   logic [bpf_pkg::T_W-1:0]            u;
   logic [33:0]                        uu_ff, tt_ff, ut_ff;
   logic [48:0]                        c_ff [4];
   logic [bpf_pkg::W_W-1:0]            w_ff [4];
   logic [50:0]                        c1_x3, c2_x3;
   logic [bpf_pkg::W_W-1:0]            w_sel;
   logic signed [bpf_pkg::COORD_W-1:0] cx_sel, cy_sel;
   logic signed [40:0]                 plo_x_ff, plo_y_ff;
   logic signed [41:0]                 phi_x_ff, phi_y_ff;
   logic signed [bpf_pkg::ACC_W-1:0]   acc_x_ff, acc_y_ff;
   logic signed [bpf_pkg::ACC_W-1:0]   acc_x_in, acc_y_in;
   logic                               out_valid_ff;
   bpf_pkg::rsp_type                   out_ff;

   function automatic logic signed [bpf_pkg::COORD_W-1:0] round_sat(
      input logic signed [bpf_pkg::ACC_W-1:0] acc
   );
      logic signed [bpf_pkg::ACC_W-1:0] v;
      logic signed [27:0]               r;
      v = acc + (bpf_pkg::ACC_W'(1) << 31);
      r = v[59:32];
      if (r[27:23] == 5'b00000 || r[27:23] == 5'b11111) begin
         round_sat = r[23:0];
      end else if (r[27]) begin
         round_sat = 24'sh800000;
      end else begin
         round_sat = 24'sh7fffff;
      end
   endfunction

   always_comb begin
      if (req_data.segments == '0) begin
         seg_eff = bpf_pkg::SEG_W'(1);
      end else if (req_data.segments > SEG_MAX) begin
         seg_eff = SEG_MAX;
      end else begin
         seg_eff = req_data.segments;
      end
   end

   // restoring division of 1.0 by the segment count
   always_comb begin
      div_shift = {rem_ff, dq_ff[bpf_pkg::T_W-1]};
      if (div_shift >= seg_ff) begin
         rem_in = 6'(div_shift - seg_ff);
         dq_in  = {dq_ff[bpf_pkg::T_W-2:0], 1'b1};
      end else begin
         rem_in = div_shift[5:0];
         dq_in  = {dq_ff[bpf_pkg::T_W-2:0], 1'b0};
      end
   end

   // t advances by quotient and remainder of 1.0 / segments
   always_comb begin
      r_sum = {1'b0, r_ff} + {1'b0, rem_ff};
      if (r_sum >= seg_ff) begin
         r_in = 6'(r_sum - seg_ff);
         q_in = q_ff + dq_ff + bpf_pkg::T_W'(1);
      end else begin
         r_in = r_sum[5:0];
         q_in = q_ff + dq_ff;
      end
   end

   assign u     = ONE_T - q_ff;
   assign c1_x3 = {1'b0, c_ff[1], 1'b0} + {2'b00, c_ff[1]} + 51'd32768;
   assign c2_x3 = {1'b0, c_ff[2], 1'b0} + {2'b00, c_ff[2]} + 51'd32768;

   always_comb begin
      w_sel = w_ff[cmd.sel];
      case (cmd.sel)
         2'd0: begin
            cx_sel = pen_x_ff;
            cy_sel = pen_y_ff;
         end
         2'd1: begin
            cx_sel = c1x_ff;
            cy_sel = c1y_ff;
         end
         2'd2: begin
            cx_sel = (kind_ff == bpf_pkg::KIND_CUBIC) ? c2x_ff : ex_ff;
            cy_sel = (kind_ff == bpf_pkg::KIND_CUBIC) ? c2y_ff : ey_ff;
         end
         default: begin
            cx_sel = ex_ff;
            cy_sel = ey_ff;
         end
      endcase
   end

   assign acc_x_in = acc_x_ff + ({{18{phi_x_ff[41]}}, phi_x_ff} << 16)
                   + {{19{plo_x_ff[40]}}, plo_x_ff};
   assign acc_y_in = acc_y_ff + ({{18{phi_y_ff[41]}}, phi_y_ff} << 16)
                   + {{19{plo_y_ff[40]}}, plo_y_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_data.kind;
         c1x_ff  <= req_data.ctrl1_x;
         c1y_ff  <= req_data.ctrl1_y;
         c2x_ff  <= req_data.ctrl2_x;
         c2y_ff  <= req_data.ctrl2_y;
         ex_ff   <= req_data.end_x;
         ey_ff   <= req_data.end_y;
         seg_ff  <= seg_eff;
         rem_ff  <= '0;
         dq_ff   <= ONE_T;
         q_ff    <= '0;
         r_ff    <= {1'b0, seg_eff[5:1]} | {seg_eff[6], 5'b00000};
         i_ff    <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
      if (cmd.t_step) begin
         q_ff <= q_in;
         r_ff <= r_in;
         i_ff <= i_ff + IW'(1);
      end
      if (cmd.prod1) begin
         uu_ff <= u * u;
         tt_ff <= q_ff * q_ff;
         ut_ff <= u * q_ff;
      end
      if (cmd.prod2) begin
         c_ff[0] <= {15'd0, uu_ff} * {32'd0, u};
         c_ff[1] <= {15'd0, uu_ff} * {32'd0, q_ff};
         c_ff[2] <= {15'd0, tt_ff} * {32'd0, u};
         c_ff[3] <= {15'd0, tt_ff} * {32'd0, q_ff};
      end
      if (cmd.weight) begin
         if (kind_ff == bpf_pkg::KIND_CUBIC) begin
            w_ff[0] <= 33'((c_ff[0] + 49'd32768) >> 16);
            w_ff[1] <= c1_x3[48:16];
            w_ff[2] <= c2_x3[48:16];
            w_ff[3] <= 33'((c_ff[3] + 49'd32768) >> 16);
         end else begin
            w_ff[0] <= uu_ff[32:0];
            w_ff[1] <= {ut_ff[31:0], 1'b0};
            w_ff[2] <= tt_ff[32:0];
            w_ff[3] <= '0;
         end
      end
      if (cmd.mul) begin
         plo_x_ff <= cx_sel * $signed({1'b0, w_sel[15:0]});
         plo_y_ff <= cy_sel * $signed({1'b0, w_sel[15:0]});
         phi_x_ff <= cx_sel * $signed({1'b0, w_sel[32:16]});
         phi_y_ff <= cy_sel * $signed({1'b0, w_sel[32:16]});
      end
      if (cmd.acc_clr) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
      end
      if (cmd.emit_point) begin
         out_ff.out_x      <= round_sat(acc_x_ff);
         out_ff.out_y      <= round_sat(acc_y_ff);
         out_ff.last_point <= status.last;
      end else if (cmd.emit_end) begin
         out_ff.out_x      <= ex_ff;
         out_ff.out_y      <= ey_ff;
         out_ff.last_point <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.pen_update) begin
            pen_x_ff <= ex_ff;
            pen_y_ff <= ey_ff;
         end
         if (cmd.emit_point || cmd.emit_end) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.last     = (7'(i_ff) == seg_ff);
   assign status.out_free = !out_valid_ff || !rsp_stall;
   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_ff;

endmodule

// ===== src/bpf_controller.sv =====
`timescale 1ns / 1ps

module bpf_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_curve,
   output logic                req_stall,
   input  bpf_pkg::status_type status,
   output bpf_pkg::cmd_type    cmd
);

   localparam logic [4:0] DIV_LAST = 5'd16;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DIV    = 10'b0000000010,
      S_TSTEP  = 10'b0000000100,
      S_PROD1  = 10'b0000001000,
      S_PROD2  = 10'b0000010000,
      S_WEIGHT = 10'b0000100000,
      S_MUL    = 10'b0001000000,
      S_ACC    = 10'b0010000000,
      S_ROUND  = 10'b0100000000,
      S_EMIT   = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] k_ff, k_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.sel  = k_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            k_in   = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = req_curve ? S_DIV : S_EMIT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_TSTEP;
            end
         end
         S_TSTEP: begin
            cmd.t_step = 1'b1;
            state_in   = S_PROD1;
         end
         S_PROD1: begin
            cmd.prod1 = 1'b1;
            state_in  = S_PROD2;
         end
         S_PROD2: begin
            cmd.prod2 = 1'b1;
            state_in  = S_WEIGHT;
         end
         S_WEIGHT: begin
            cmd.weight = 1'b1;
            k_in       = '0;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.mul     = 1'b1;
            cmd.acc_clr = (k_ff == 2'd0);
            cmd.acc_en  = (k_ff != 2'd0);
            k_in        = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = S_ROUND;
         end
         S_ROUND: begin
            if (status.out_free) begin
               cmd.emit_point = 1'b1;
               if (status.last) begin
                  cmd.pen_update = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_TSTEP;
               end
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_end   = 1'b1;
               cmd.pen_update = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== src/bpf_checker.sv =====
`timescale 1ns / 1ps

module bpf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input bpf_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bpf_pkg::rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // curve in progress blocks the next command
   a_curve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind[1] |=> req_stall)
      else $error("command taken during curve");

   // move or line into an empty output gives its end point
   a_move_point: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.kind[1] && !rsp_valid |=> ##1
      rsp_valid && rsp_data.last_point
      && rsp_data.out_x == $past(req_data.end_x, 2)
      && rsp_data.out_y == $past(req_data.end_y, 2))
      else $error("move or line point wrong");

endmodule

bind bezier_path_flattener_top bpf_checker u_bpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/bezier_path_flattener_checker.sv =====
`timescale 1ns / 1ps

module bezier_path_flattener_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bpf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bpf_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               points_pending
);

   localparam longint COORD_HI = 64'sd8388607;
   localparam longint COORD_LO = -64'sd8388608;
   localparam int     SEG_MAX  = 64;

   bpf_pkg::rsp_type                   points_due[$];
   logic signed [bpf_pkg::COORD_W-1:0] pen_x, pen_y;

   function automatic logic signed [bpf_pkg::COORD_W-1:0] to_coord(longint sum);
      longint r;
      r = (sum + (64'sd1 <<< 31)) >>> 32;
      if (r > COORD_HI) r = COORD_HI;
      if (r < COORD_LO) r = COORD_LO;
      return r[bpf_pkg::COORD_W-1:0];
   endfunction

   function automatic longint rnd16(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic void flatten_command(bpf_pkg::req_type c);
      int unsigned seg;
      longint t, u, w0, w1, w2, w3, sx, sy;
      bpf_pkg::rsp_type p;
      if (c.kind == bpf_pkg::KIND_MOVE || c.kind == bpf_pkg::KIND_LINE) begin
         p.out_x = c.end_x;
         p.out_y = c.end_y;
         p.last_point = 1'b1;
         points_due = {points_due, p};
      end else begin
         seg = c.segments;
         if (seg < 1) seg = 1;
         if (seg > SEG_MAX) seg = SEG_MAX;
         for (int unsigned i = 1; i <= seg; i++) begin
            t = (longint'(i) * 65536 + seg / 2) / seg;
            u = 65536 - t;
            if (c.kind == bpf_pkg::KIND_QUAD) begin
               w0 = u * u;
               w1 = 2 * u * t;
               w2 = t * t;
               sx = w0 * pen_x + w1 * c.ctrl1_x + w2 * c.end_x;
               sy = w0 * pen_y + w1 * c.ctrl1_y + w2 * c.end_y;
            end else begin
               w0 = rnd16(u * u * u);
               w1 = rnd16(3 * u * u * t);
               w2 = rnd16(3 * u * t * t);
               w3 = rnd16(t * t * t);
               sx = w0 * pen_x + w1 * c.ctrl1_x + w2 * c.ctrl2_x + w3 * c.end_x;
               sy = w0 * pen_y + w1 * c.ctrl1_y + w2 * c.ctrl2_y + w3 * c.end_y;
            end
            p.out_x = to_coord(sx);
            p.out_y = to_coord(sy);
            p.last_point = (i == seg);
            points_due = {points_due, p};
         end
      end
      pen_x = c.end_x;
      pen_y = c.end_y;
   endfunction

   always @(posedge clock) begin
      bpf_pkg::rsp_type want;
      if (reset) begin
         pen_x = '0;
         pen_y = '0;
         points_due.delete();
      end else begin
         if (req_valid && !req_stall) flatten_command(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (points_due.size() == 0) begin
               $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                        rsp_data.out_x, rsp_data.out_y, rsp_data.last_point);
               fail_count <= fail_count + 1;
            end else begin
               want = points_due.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                           $time, want.out_x, want.out_y, want.last_point,
                           rsp_data.out_x, rsp_data.out_y, rsp_data.last_point);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      points_pending <= points_due.size();
   end

   initial begin
      fail_count = 0;
      points_pending = 0;
   end

endmodule

// ===== tb/bezier_path_flattener_top_tb.sv =====
`timescale 1ns / 1ps

module bezier_path_flattener_top_tb;

   localparam int CYCLE_LIMIT = 2000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bpf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   bpf_pkg::rsp_type rsp_data;
   int               fail_count, points_pending;
   int               idle_pct = 0;
   int               stall_pct = 0;
   int               cycles = 0;

   bezier_path_flattener_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   bezier_path_flattener_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .points_pending(points_pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      if (cycles > CYCLE_LIMIT) begin
         $display("bezier_path_flattener_top_tb: errors");
         $finish;
      end
   end

   function automatic logic [23:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 24'h7fffff;
         1: return 24'h800000;
         2: return 24'($signed($urandom_range(0, 4095)) - 2048);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic bpf_pkg::req_type random_command();
      bpf_pkg::req_type c;
      c.kind = 2'($urandom);
      c.ctrl1_x = pick_coord();
      c.ctrl1_y = pick_coord();
      c.ctrl2_x = pick_coord();
      c.ctrl2_y = pick_coord();
      c.end_x = pick_coord();
      c.end_y = pick_coord();
      case ($urandom_range(0, 19))
         0: c.segments = 7'($urandom);
         1: c.segments = 7'd64;
         2: c.segments = 7'd0;
         default: c.segments = 7'($urandom_range(1, 8));
      endcase
      return c;
   endfunction

   function automatic bpf_pkg::req_type command(logic [1:0] k, logic [23:0] c1x,
                                                logic [23:0] c1y,
                                                logic [23:0] c2x, logic [23:0] c2y,
                                                logic [23:0] ex, logic [23:0] ey,
                                                logic [6:0] s);
      bpf_pkg::req_type c;
      c.kind = k;
      c.ctrl1_x = c1x; c.ctrl1_y = c1y;
      c.ctrl2_x = c2x; c.ctrl2_y = c2y;
      c.end_x = ex; c.end_y = ey;
      c.segments = s;
      return c;
   endfunction

   task automatic send(bpf_pkg::req_type c);
      int gap;
      req_data <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(command(bpf_pkg::KIND_QUAD, 24'h000100, 24'h000200, 24'h7fffff, 24'h7fffff,
                   24'h000400, 24'h000800, 7'd4));
      send(command(bpf_pkg::KIND_MOVE, 24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                   24'h7fffff, 24'h800000, 7'd127));
      send(command(bpf_pkg::KIND_LINE, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                   24'h800000, 24'h7fffff, 7'd0));
      send(command(bpf_pkg::KIND_QUAD, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000,
                   24'h7fffff, 24'h800000, 7'd0));
      send(command(bpf_pkg::KIND_QUAD, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff,
                   24'h000000, 24'h000000, 7'd64));
      send(command(bpf_pkg::KIND_CUBIC, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000,
                   24'h7fffff, 24'h7fffff, 7'd3));
      send(command(bpf_pkg::KIND_CUBIC, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000,
                   24'h800000, 24'h800000, 7'd127));
      send(command(bpf_pkg::KIND_CUBIC, 24'h000080, 24'hffff80, 24'h001000, 24'hfff000,
                   24'h000001, 24'hffffff, 7'd1));
      send(command(bpf_pkg::KIND_MOVE, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 7'd0));
      send(command(bpf_pkg::KIND_CUBIC, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                   24'h7fffff, 24'h7fffff, 7'd65));
      send(command(bpf_pkg::KIND_LINE, 24'h0, 24'h0, 24'h0, 24'h0, 24'h123456, 24'hedcba9,
                   7'd5));
      send(command(bpf_pkg::KIND_QUAD, 24'h555555, 24'haaaaaa, 24'h0, 24'h0,
                   24'haaaaaa, 24'h555555, 7'd7));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         for (int n = 0; n < 55; n++) send(random_command());
         drain();
      end
      idle_pct = 0;
      stall_pct = 0;
      repeat (40) @(posedge clock);

      if (fail_count == 0 && points_pending == 0)
         $display("bezier_path_flattener_top_tb: clean");
      else
         $display("bezier_path_flattener_top_tb: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bpf_pkg.sv
src/bpf_datapath.sv
src/bpf_controller.sv
src/bezier_path_flattener_top.sv
src/bpf_checker.sv
tb/bezier_path_flattener_checker.sv
tb/bezier_path_flattener_top_tb.sv
